// ===== rtl/indexed_list_engine_defines.svh =====
// assertion macros for the indexed list engine
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every clock edge outside reset
`define ILE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed list engine check failed");
// next-cycle implication
`define ILE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("indexed list engine check failed");
`else
`define ILE_ASSERT_IMPL(label, ante, cons)
`define ILE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/ile_pkg.sv =====
// shared types and codes for the indexed list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    // port field widths
    localparam int FUNC_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // request codes
    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ERASE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REVERSE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // store port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // one finished result
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic [VAL_W-1:0]  rdata;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ile_mem.sv =====
// list store: one write port and one registered read port
// depends on ile_pkg
`timescale 1ns / 1ps
`default_nettype none

module ile_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire                  i_clk,
    input  wire ile_pkg::t_mem_ctl i_ctl,
    input  wire  [AW-1:0]        i_waddr,
    input  wire  [WIDTH-1:0]     i_wdata,
    input  wire  [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    import ile_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ile_ctrl.sv =====
// request sequencer: decodes a request and shifts entries through the store with one
// shared index stepper, one entry move per cycle; a reverse swaps pairs instead
// depends on ile_pkg
`timescale 1ns / 1ps
`default_nettype none

module ile_ctrl #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  wire  [ile_pkg::FUNC_W-1:0]   i_func,
    input  wire  [ile_pkg::POS_W-1:0]    i_position,
    input  wire  [ile_pkg::VAL_W-1:0]    i_value,
    output logic                         o_busy,
    output logic                         o_done,
    output ile_pkg::t_result             o_res,
    output ile_pkg::t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]                o_waddr,
    output logic [WIDTH-1:0]             o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  wire  [WIDTH-1:0]             i_rdata
);
    import ile_pkg::*;

    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOVE  = 3'd1;
    localparam logic [2:0] S_REV_A = 3'd2;
    localparam logic [2:0] S_REV_B = 3'd3;
    localparam logic [2:0] S_REV_C = 3'd4;
    localparam logic [2:0] S_REV_D = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // control state
    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_pend,  n_pend;
    // payload state
    logic [CW-1:0]     r_rem,   n_rem;
    logic [AW-1:0]     r_ptr,   n_ptr;
    logic [AW-1:0]     r_last,  n_last;
    logic [AW-1:0]     r_hi,    n_hi;
    logic [AW-1:0]     r_pos,   n_pos;
    logic [WIDTH-1:0]  r_val,   n_val;
    logic [WIDTH-1:0]  r_tmp,   n_tmp;
    logic              r_ins,   n_ins;
    logic              r_rdsel, n_rdsel;
    logic [STAT_W-1:0] r_status, n_status;

    logic [CMPW-1:0]   pos_c;
    logic [CMPW-1:0]   cnt_c;
    logic [CMPW-1:0]   span;
    logic [AW-1:0]     pos_a;
    logic              full;
    logic [AW-1:0]     ptr_step;
    logic [AW-1:0]     dest;
    logic [WIDTH-1:0]  val_w;
    logic [VAL_W-1:0]  rd_ext;

    // fit the input word to the store width and the stored word to the port
    for (genvar g = 0; g < WIDTH; g++) begin : g_val
        if (g < VAL_W) begin : g_in
            assign val_w[g] = i_value[g];
        end else begin : g_pad
            assign val_w[g] = 1'b0;
        end
    end
    for (genvar g = 0; g < VAL_W; g++) begin : g_rd
        if (g < WIDTH) begin : g_in
            assign rd_ext[g] = i_rdata[g];
        end else begin : g_pad
            assign rd_ext[g] = 1'b0;
        end
    end

    // request decode helpers
    assign pos_c = CMPW'(i_position);
    assign cnt_c = CMPW'(r_count);
    assign span  = cnt_c - pos_c;
    assign pos_a = pos_c[AW-1:0];
    assign full  = (r_count == CW'(DEPTH));

    // shared index stepper: source walks one way, destination is one off
    assign ptr_step = r_ins ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
    assign dest     = r_ins ? (r_last + AW'(1)) : (r_last - AW'(1));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pend    = r_pend;
        n_rem     = r_rem;
        n_ptr     = r_ptr;
        n_last    = r_last;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_val     = r_val;
        n_tmp     = r_tmp;
        n_ins     = r_ins;
        n_rdsel   = r_rdsel;
        n_status  = r_status;
        o_mem_ctl = '0;
        o_waddr   = r_pos;
        o_wdata   = r_val;
        o_raddr   = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_status = ST_OK;
                    n_rdsel  = 1'b0;
                    n_pend   = 1'b0;
                    n_val    = val_w;
                    n_state  = S_DONE;
                    case (i_func)
                        FN_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                // insert at the end with nothing to move
                                n_ins   = 1'b1;
                                n_pos   = r_count[AW-1:0];
                                n_rem   = '0;
                                n_state = S_MOVE;
                            end
                        end
                        FN_INSERT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_c > cnt_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_ins   = 1'b1;
                                n_pos   = pos_a;
                                n_rem   = span[CW-1:0];
                                n_ptr   = r_count[AW-1:0] - AW'(1);
                                n_state = S_MOVE;
                            end
                        end
                        FN_ERASE: begin
                            if (pos_c >= cnt_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_ins   = 1'b0;
                                n_rem   = span[CW-1:0] - CW'(1);
                                n_ptr   = pos_a + AW'(1);
                                n_state = S_MOVE;
                            end
                        end
                        FN_REVERSE: begin
                            n_rem   = r_count >> 1;
                            n_ptr   = '0;
                            n_hi    = r_count[AW-1:0] - AW'(1);
                            n_state = S_REV_A;
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                        end
                        FN_READ: begin
                            if (pos_c >= cnt_c) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem_ctl.rd_en = 1'b1;
                                o_raddr         = pos_a;
                                n_rdsel         = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // at most one read and one write per cycle until the span is moved
            S_MOVE: begin
                if (r_pend) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_waddr         = dest;
                    o_wdata         = i_rdata;
                end
                if (r_rem != '0) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_ptr;
                    n_last          = r_ptr;
                    n_ptr           = ptr_step;
                    n_rem           = r_rem - CW'(1);
                    n_pend          = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_ins) begin
                            o_mem_ctl.wr_en = 1'b1;
                            o_waddr         = r_pos;
                            o_wdata         = r_val;
                            n_count         = r_count + CW'(1);
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                        n_state = S_DONE;
                    end
                end
            end

            // swap one pair: read low, read high, write low, write high
            S_REV_A: begin
                if (r_rem != '0) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_ptr;
                    n_state         = S_REV_B;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV_B: begin
                n_tmp           = i_rdata;
                o_mem_ctl.rd_en = 1'b1;
                o_raddr         = r_hi;
                n_state         = S_REV_C;
            end
            S_REV_C: begin
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = r_ptr;
                o_wdata         = i_rdata;
                n_state         = S_REV_D;
            end
            S_REV_D: begin
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = r_hi;
                o_wdata         = r_tmp;
                n_ptr           = r_ptr + AW'(1);
                n_hi            = r_hi - AW'(1);
                n_rem           = r_rem - CW'(1);
                n_state         = S_REV_A;
            end

            S_DONE: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_ptr    <= n_ptr;
        r_last   <= n_last;
        r_hi     <= n_hi;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_tmp    <= n_tmp;
        r_ins    <= n_ins;
        r_rdsel  <= n_rdsel;
        r_status <= n_status;
    end

    // result of the finished request
    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.count  = CNT_W'(r_count);
    assign o_res.rdata  = r_rdsel ? rd_ext : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_engine.sv =====
// Throughput: one request at a time, bounded by one entry move per cycle through
// the single write port and registered read port of the store.
// Reset (synchronous, active low) empties the list; store contents stay undefined.
// o_valid is a one-cycle strobe; results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_list_engine_defines.svh"

module indexed_list_engine #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [ile_pkg::FUNC_W-1:0]   i_func,
    input  wire  [ile_pkg::POS_W-1:0]    i_position,
    input  wire  [ile_pkg::VAL_W-1:0]    i_value,
    output logic                         o_valid,
    output logic [ile_pkg::STAT_W-1:0]   o_status,
    output logic [ile_pkg::CNT_W-1:0]    o_count,
    output logic [ile_pkg::VAL_W-1:0]    o_read_value
);
    import ile_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             accept;
    logic             done;
    t_result          res;
    t_mem_ctl         mem_ctl;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [WIDTH-1:0] wdata;
    logic [WIDTH-1:0] rdata;
    logic             r_valid;
    t_result          r_res;

    // request transfer
    assign accept = start && !busy;

    ile_ctrl #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (i_func),
        .i_position (i_position),
        .i_value    (i_value),
        .o_busy     (busy),
        .o_done     (done),
        .o_res      (res),
        .o_mem_ctl  (mem_ctl),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    ile_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result strobe register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= done;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_res <= res;
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_res.status;
    assign o_count      = r_res.count;
    assign o_read_value = r_res.rdata;

    // every accepted request makes the engine busy in the next cycle
    `ILE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // result transfers never come back to back
    `ILE_ASSERT_NEXT(a_valid_gap, o_valid, !o_valid)
    // a rejected request returns no read data
    `ILE_ASSERT_IMPL(a_fail_no_data, o_valid && (o_status != ST_OK), o_read_value == '0)

endmodule

`default_nettype wire
